### hdl/iirdac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR DAC package
// Shared constants and types for the third-order IIR output driver.
// ----------------------------------------------------------------------------
package iirdac_pkg;

    localparam int DEF_FILTER_ORDER = 3;
    localparam int DEF_COEF_WIDTH   = 32;
    localparam int DEF_STATE_WIDTH  = 48;
    localparam int DEF_COUNT_WIDTH  = 24;

    localparam int FIFO_DEPTH  = 2;
    localparam int FRAC_BITS   = 28;
    localparam int LEVEL_WIDTH = 8;
    localparam int DRIVE_WIDTH = 16;
    localparam int OUT_SHIFT   = 15;
    localparam int PERIOD_WIDTH = 24;

    // Pin level bias and the volts-per-step factor in Q.28.
    localparam int LEVEL_BIAS = 30;
    localparam int CONV_K     = 6040402;
    localparam int FIVE_VOLTS = 5;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 64;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SAMPLE_PERIOD = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INPUT_ENABLE  = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_IN_GAIN_OFS   = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUT_GAIN_OFS  = 8'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NUMERATOR_01  = 8'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NUMERATOR_23  = 8'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DENOMINATOR_12 = 8'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DENOMINATOR_3 = 8'd7;

    typedef struct packed {
        logic [63:0] input_gain_offset;
        logic [63:0] output_gain_offset;
        logic [63:0] numerator_01;
        logic [63:0] numerator_23;
        logic [63:0] denominator_12;
        logic [31:0] denominator_3;
    } coef_t;

endpackage

### hdl/iir_transfer_function_dac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR transfer function DAC
// Decimated third-order direct-form-II IIR filter driving a 0..5 V output.
// ----------------------------------------------------------------------------
// Each pushed item is one clock tick with a pin level. Ticks are taken in one
// cycle each while the two-entry level queue has room; a tick whose count
// exceeds sample_period (with input_enable set) queues its level for the
// filter. The filter steps through its taps one at a time, each tap passing
// through the low product, high product, sum and accumulate states. Results
// wait in a two-entry queue, read with pop while empty is low, in 1/8192 V.
// Configuration writes are always ready and take effect on the next cycle.
// ----------------------------------------------------------------------------
module iir_transfer_function_dac
    import iirdac_pkg::*;
#(
    parameter int FILTER_ORDER = DEF_FILTER_ORDER,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
    parameter int STATE_WIDTH  = DEF_STATE_WIDTH,
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [LEVEL_WIDTH-1:0]     pin_level,
    output logic                       empty,
    input  logic                       pop,
    output logic [DRIVE_WIDTH-1:0]     drive_volts,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic [PERIOD_WIDTH-1:0] sample_period_reg;
    logic                    input_enable_reg;
    coef_t                   coefs_reg;

    logic                    lq_push;
    logic                    lq_full;
    logic                    lq_pop;
    logic                    lq_empty;
    logic [LEVEL_WIDTH-1:0]  lq_din;
    logic [LEVEL_WIDTH-1:0]  lq_dout;
    logic                    oq_push;
    logic                    oq_full;
    logic [DRIVE_WIDTH-1:0]  oq_din;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= '0;
            input_enable_reg  <= 1'b0;
            coefs_reg         <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SAMPLE_PERIOD:  sample_period_reg <= cfg_data[PERIOD_WIDTH-1:0];
                REG_INPUT_ENABLE:   input_enable_reg  <= cfg_data[0];
                REG_IN_GAIN_OFS:    coefs_reg.input_gain_offset  <= cfg_data;
                REG_OUT_GAIN_OFS:   coefs_reg.output_gain_offset <= cfg_data;
                REG_NUMERATOR_01:   coefs_reg.numerator_01   <= cfg_data;
                REG_NUMERATOR_23:   coefs_reg.numerator_23   <= cfg_data;
                REG_DENOMINATOR_12: coefs_reg.denominator_12 <= cfg_data;
                REG_DENOMINATOR_3:  coefs_reg.denominator_3  <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    iirdac_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .pin_level     (pin_level),
        .full          (full),
        .sample_period (sample_period_reg),
        .input_enable  (input_enable_reg),
        .q_push        (lq_push),
        .q_data        (lq_din),
        .q_full        (lq_full)
    );

    iirdac_fifo #(
        .WIDTH(LEVEL_WIDTH),
        .DEPTH(FIFO_DEPTH)
    ) u_level_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (lq_push),
        .din   (lq_din),
        .full  (lq_full),
        .pop   (lq_pop),
        .dout  (lq_dout),
        .empty (lq_empty)
    );

    iirdac_back #(
        .FILTER_ORDER(FILTER_ORDER),
        .COEF_WIDTH  (COEF_WIDTH),
        .STATE_WIDTH (STATE_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .coefs   (coefs_reg),
        .q_empty (lq_empty),
        .q_data  (lq_dout),
        .q_pop   (lq_pop),
        .o_full  (oq_full),
        .o_push  (oq_push),
        .o_data  (oq_din)
    );

    iirdac_fifo #(
        .WIDTH(DRIVE_WIDTH),
        .DEPTH(FIFO_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .din   (oq_din),
        .full  (oq_full),
        .pop   (pop),
        .dout  (drive_volts),
        .empty (empty)
    );

endmodule

### hdl/iirdac_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR DAC queue
// Small first-in first-out buffer with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module iirdac_fifo
    import iirdac_pkg::*;
#(
    parameter int WIDTH = LEVEL_WIDTH,
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/iirdac_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR DAC front end
// Tick decimation: decides which ticks start a filter update.
// ----------------------------------------------------------------------------
module iirdac_front
    import iirdac_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [LEVEL_WIDTH-1:0]  pin_level,
    output logic                    full,
    input  logic [PERIOD_WIDTH-1:0] sample_period,
    input  logic                    input_enable,
    output logic                    q_push,
    output logic [LEVEL_WIDTH-1:0]  q_data,
    input  logic                    q_full
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > PERIOD_WIDTH) ? COUNT_WIDTH : PERIOD_WIDTH;

    logic [COUNT_WIDTH-1:0] tick_count_reg;
    logic [COUNT_WIDTH-1:0] tick_count_next;
    logic                   accept;
    logic                   waiting;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign waiting = CMP_WIDTH'(tick_count_reg) <= CMP_WIDTH'(sample_period);
    assign q_push  = accept && !waiting && input_enable;
    assign q_data  = pin_level;

    always_comb
    begin
        tick_count_next = tick_count_reg;
        if (accept)
        begin
            priority if (waiting)
            begin
                // The counter sticks at all ones.
                if (tick_count_reg != '1)
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                end
            end
            else if (input_enable)
            begin
                tick_count_next = COUNT_WIDTH'(1);
            end
            else
            begin
                tick_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
        end
    end

endmodule

### hdl/iirdac_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR DAC back end
// Shared multiply-accumulate sequencer for the direct-form-II filter.
// ----------------------------------------------------------------------------
module iirdac_back
    import iirdac_pkg::*;
#(
    parameter int FILTER_ORDER = DEF_FILTER_ORDER,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
    parameter int STATE_WIDTH  = DEF_STATE_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  coef_t                  coefs,
    input  logic                   q_empty,
    input  logic [LEVEL_WIDTH-1:0] q_data,
    output logic                   q_pop,
    input  logic                   o_full,
    output logic                   o_push,
    output logic [DRIVE_WIDTH-1:0] o_data
);

    localparam int SW = STATE_WIDTH;
    localparam int CW = COEF_WIDTH;
    localparam int H  = SW / 2;
    localparam int PW = SW + CW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MLO  = 3'd1;
    localparam logic [2:0] ST_MHI  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;

    localparam logic [3:0] OP_IN  = 4'd0;
    localparam logic [3:0] OP_FB1 = 4'd1;
    localparam logic [3:0] OP_FB2 = 4'd2;
    localparam logic [3:0] OP_FB3 = 4'd3;
    localparam logic [3:0] OP_FF0 = 4'd4;
    localparam logic [3:0] OP_FF1 = 4'd5;
    localparam logic [3:0] OP_FF2 = 4'd6;
    localparam logic [3:0] OP_FF3 = 4'd7;
    localparam logic [3:0] OP_OUT = 4'd8;

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] FIVE_Q = SW'(FIVE_VOLTS) <<< FRAC_BITS;

    function automatic logic signed [SW-1:0] sat_sum(input logic signed [SW:0] s);
        logic signed [SW-1:0] r;
        r = s[SW-1:0];
        if (s[SW] != s[SW-1])
        begin
            r = s[SW] ? SMIN : SMAX;
        end
        return r;
    endfunction

    logic [2:0]              state_reg;
    logic [3:0]              op_reg;
    logic [3:0]              op_next;
    logic signed [SW-1:0]    x_reg;
    logic signed [SW-1:0]    w_reg;
    logic signed [SW-1:0]    y_reg;
    logic signed [SW-1:0]    d_reg [3];
    logic signed [SW-1:0]    mq_reg;
    logic signed [H+CW:0]    plo_reg;
    logic signed [SW-H+CW-1:0] phi_reg;

    logic signed [SW-1:0]    opa;
    logic signed [CW-1:0]    opc;
    logic signed [H:0]       a_lo;
    logic signed [SW-H-1:0]  a_hi;
    logic signed [PW-1:0]    prod;
    logic signed [PW-1:0]    prod_q;
    logic signed [SW-1:0]    mq_sat;
    logic signed [SW-1:0]    in_ofs;
    logic signed [SW-1:0]    out_ofs;
    logic signed [SW-1:0]    o_sum;
    logic signed [SW-1:0]    o_clamp;
    logic signed [LEVEL_WIDTH:0] level_s;
    logic signed [LEVEL_WIDTH+24:0] x_calc;

    assign in_ofs  = SW'($signed(coefs.input_gain_offset[CW-1:0]));
    assign out_ofs = SW'($signed(coefs.output_gain_offset[CW-1:0]));

    always_comb
    begin
        unique case (op_reg)
            OP_IN:
            begin
                opa = x_reg;
                opc = coefs.input_gain_offset[32+CW-1:32];
            end
            OP_FB1:
            begin
                opa = d_reg[0];
                opc = coefs.denominator_12[32+CW-1:32];
            end
            OP_FB2:
            begin
                opa = d_reg[1];
                opc = coefs.denominator_12[CW-1:0];
            end
            OP_FB3:
            begin
                opa = d_reg[2];
                opc = coefs.denominator_3[CW-1:0];
            end
            OP_FF0:
            begin
                opa = w_reg;
                opc = coefs.numerator_01[32+CW-1:32];
            end
            OP_FF1:
            begin
                opa = d_reg[0];
                opc = coefs.numerator_01[CW-1:0];
            end
            OP_FF2:
            begin
                opa = d_reg[1];
                opc = coefs.numerator_23[32+CW-1:32];
            end
            OP_FF3:
            begin
                opa = d_reg[2];
                opc = coefs.numerator_23[CW-1:0];
            end
            default:
            begin
                opa = y_reg;
                opc = coefs.output_gain_offset[32+CW-1:32];
            end
        endcase
    end

    // Taps above the filter order are skipped.
    always_comb
    begin
        unique case (op_reg)
            OP_IN:   op_next = OP_FB1;
            OP_FB1:  op_next = (FILTER_ORDER >= 2) ? OP_FB2 : OP_FF0;
            OP_FB2:  op_next = (FILTER_ORDER >= 3) ? OP_FB3 : OP_FF0;
            OP_FB3:  op_next = OP_FF0;
            OP_FF0:  op_next = OP_FF1;
            OP_FF1:  op_next = (FILTER_ORDER >= 2) ? OP_FF2 : OP_OUT;
            OP_FF2:  op_next = (FILTER_ORDER >= 3) ? OP_FF3 : OP_OUT;
            default: op_next = OP_OUT;
        endcase
    end

    // The state operand is split so each partial product stays narrow.
    assign a_lo = $signed({1'b0, opa[H-1:0]});
    assign a_hi = opa[SW-1:H];

    assign prod   = (PW'(phi_reg) <<< H) + PW'(plo_reg);
    assign prod_q = prod >>> FRAC_BITS;

    always_comb
    begin
        priority if (prod_q > PW'(SMAX))
        begin
            mq_sat = SMAX;
        end
        else if (prod_q < PW'(SMIN))
        begin
            mq_sat = SMIN;
        end
        else
        begin
            mq_sat = prod_q[SW-1:0];
        end
    end

    assign level_s = $signed({1'b0, q_data}) - (LEVEL_WIDTH+1)'(LEVEL_BIAS);
    assign x_calc  = level_s * $signed({1'b0, 24'(CONV_K)});

    assign o_sum = sat_sum((SW+1)'(mq_reg) + (SW+1)'(out_ofs));

    always_comb
    begin
        priority if (o_sum[SW-1])
        begin
            o_clamp = '0;
        end
        else if (o_sum > FIVE_Q)
        begin
            o_clamp = FIVE_Q;
        end
        else
        begin
            o_clamp = o_sum;
        end
    end

    assign o_data = o_clamp[OUT_SHIFT+DRIVE_WIDTH-1:OUT_SHIFT];
    assign o_push = (state_reg == ST_ACC) && (op_reg == OP_OUT) && !o_full;
    assign q_pop  = (state_reg == ST_IDLE) && !q_empty;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                x_reg <= SW'(x_calc);
            end
            ST_MLO:
            begin
                plo_reg <= a_lo * opc;
            end
            ST_MHI:
            begin
                phi_reg <= a_hi * opc;
            end
            ST_SUM:
            begin
                mq_reg <= mq_sat;
            end
            ST_ACC:
            begin
                unique case (op_reg)
                    OP_IN:
                    begin
                        w_reg <= sat_sum((SW+1)'(mq_reg) + (SW+1)'(in_ofs));
                    end
                    OP_FB1, OP_FB2, OP_FB3:
                    begin
                        w_reg <= sat_sum((SW+1)'(w_reg) - (SW+1)'(mq_reg));
                    end
                    OP_FF0:
                    begin
                        y_reg <= mq_reg;
                    end
                    OP_FF1, OP_FF2, OP_FF3:
                    begin
                        y_reg <= sat_sum((SW+1)'(y_reg) + (SW+1)'(mq_reg));
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_IN;
            d_reg[0]  <= '0;
            d_reg[1]  <= '0;
            d_reg[2]  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        op_reg    <= OP_IN;
                        state_reg <= ST_MLO;
                    end
                end
                ST_MLO:
                begin
                    state_reg <= ST_MHI;
                end
                ST_MHI:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (op_reg == OP_OUT)
                    begin
                        if (!o_full)
                        begin
                            d_reg[2]  <= d_reg[1];
                            d_reg[1]  <= d_reg[0];
                            d_reg[0]  <= w_reg;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        op_reg    <= op_next;
                        state_reg <= ST_MLO;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/iirdac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IIR DAC port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module iirdac_checker
    import iirdac_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   empty,
    input logic                   pop,
    input logic                   cfg_ready,
    input logic [DRIVE_WIDTH-1:0] drive_volts
);

    localparam logic [DRIVE_WIDTH-1:0] MAX_DRIVE = DRIVE_WIDTH'(FIVE_VOLTS * 8192);

    // Configuration transactions are never stalled.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

    // The output is clamped to five volts.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> drive_volts <= MAX_DRIVE)
        else $error("drive value above five volts");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(drive_volts))
        else $error("waiting result changed or vanished");

endmodule

bind iir_transfer_function_dac iirdac_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .cfg_ready   (cfg_ready),
    .drive_volts (drive_volts)
);
